// File: design/lvm_pkg.sv
package lvm_pkg;

    localparam int DATA_W = 32;
    localparam int ROW_W = 2;
    localparam logic [ROW_W-1:0] FIRST_ROW = 2'd0;
    localparam logic [ROW_W-1:0] LAST_ROW = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] eye_x;
        logic signed [DATA_W-1:0] eye_y;
        logic signed [DATA_W-1:0] eye_z;
        logic signed [DATA_W-1:0] target_x;
        logic signed [DATA_W-1:0] target_y;
        logic signed [DATA_W-1:0] target_z;
        logic signed [DATA_W-1:0] up_x;
        logic signed [DATA_W-1:0] up_y;
        logic signed [DATA_W-1:0] up_z;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] col_0;
        logic signed [DATA_W-1:0] col_1;
        logic signed [DATA_W-1:0] col_2;
        logic signed [DATA_W-1:0] col_3;
        logic [ROW_W-1:0]         row_index;
        logic                     last_row;
        logic                     degenerate;
    } t_row;

endpackage

// File: design/lvm_norm.sv
module lvm_norm #(
    parameter int IN_W  = 33,
    parameter int FRAC  = 16,
    parameter int TAG_W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [2:0][IN_W-1:0]  i_vec,
    input  logic [TAG_W-1:0]      i_tag,
    output logic                  o_valid,
    output logic [2:0][FRAC+1:0]  o_vec,
    output logic                  o_zero,
    output logic [TAG_W-1:0]      o_tag
);

    localparam int QB  = FRAC + 1;
    localparam int OW  = FRAC + 2;
    localparam int AW  = 30;
    localparam int SHW = $clog2(IN_W);
    localparam int SQ  = 32;
    localparam int NW  = FRAC + 34;
    localparam int NP  = 39 + QB;
    localparam int NS  = 36 + QB;
    localparam int DS  = 35;

    logic [NP-1:0]     r_v;

    logic [IN_W-1:0]   r_a_m [3];
    logic [2:0]        r_a_neg;
    logic [TAG_W-1:0]  r_a_tag;

    logic [IN_W-1:0]   r_b_m [3];
    logic [2:0]        r_b_neg;
    logic [TAG_W-1:0]  r_b_tag;
    logic [SHW-1:0]    r_b_sh;
    logic              r_b_right;
    logic              r_b_zero;

    logic [AW-1:0]     r_sd_a [NS][3];
    logic [2:0]        r_sd_neg [NS];
    logic              r_sd_zero [NS];
    logic [TAG_W-1:0]  r_sd_tag [NS];

    logic [2*AW-1:0]   r_sqr [3];
    logic [63:0]       r_sq_n [SQ+1];
    logic [63:0]       r_sq_r [SQ+1];
    logic [63:0]       n_sq_n [SQ+1];
    logic [63:0]       n_sq_r [SQ+1];

    logic [NW-1:0]     r_dv_rem [QB+1][3];
    logic [QB-1:0]     r_dv_q [QB+1][3];
    logic [32:0]       r_dv_d [QB+1];
    logic [NW-1:0]     n_dv_rem [QB+1][3];
    logic [QB-1:0]     n_dv_q [QB+1][3];

    logic [IN_W-1:0]   w_or;
    logic [SHW-1:0]    w_msb;
    logic [31:0]       w_len;

    always_comb begin
        w_or = r_a_m[0] | r_a_m[1] | r_a_m[2];
        w_msb = '0;
        for (int b = 0; b < IN_W; b++) begin
            if (w_or[b]) begin
                w_msb = SHW'(b);
            end
        end
    end

    always_comb begin
        logic [63:0] bitv;
        logic [63:0] t;
        n_sq_n[0] = r_sq_n[0];
        n_sq_r[0] = r_sq_r[0];
        for (int k = 0; k < SQ; k++) begin
            bitv = 64'(1) << (62 - 2 * k);
            t = r_sq_r[k] + bitv;
            if (r_sq_n[k] >= t) begin
                n_sq_n[k+1] = r_sq_n[k] - t;
                n_sq_r[k+1] = (r_sq_r[k] >> 1) + bitv;
            end else begin
                n_sq_n[k+1] = r_sq_n[k];
                n_sq_r[k+1] = r_sq_r[k] >> 1;
            end
        end
    end

    assign w_len = r_sq_r[SQ][31:0];

    always_comb begin
        logic [NW-1:0] t;
        for (int i = 0; i < 3; i++) begin
            n_dv_rem[0][i] = r_dv_rem[0][i];
            n_dv_q[0][i] = r_dv_q[0][i];
        end
        for (int j = 0; j < QB; j++) begin
            t = NW'(r_dv_d[j]) << (QB - 1 - j);
            for (int i = 0; i < 3; i++) begin
                n_dv_q[j+1][i] = r_dv_q[j][i];
                if (r_dv_rem[j][i] >= t) begin
                    n_dv_rem[j+1][i] = r_dv_rem[j][i] - t;
                    n_dv_q[j+1][i][QB-1-j] = 1'b1;
                end else begin
                    n_dv_rem[j+1][i] = r_dv_rem[j][i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[NP-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_a_neg[i] <= i_vec[i][IN_W-1];
            r_a_m[i] <= i_vec[i][IN_W-1] ? -i_vec[i] : i_vec[i];
        end
        r_a_tag <= i_tag;

        r_b_m <= r_a_m;
        r_b_neg <= r_a_neg;
        r_b_tag <= r_a_tag;
        r_b_zero <= (w_or == '0);
        r_b_right <= (w_msb >= SHW'(AW));
        r_b_sh <= (w_msb >= SHW'(AW)) ? w_msb - SHW'(AW - 1) : SHW'(AW - 1) - w_msb;

        for (int i = 0; i < 3; i++) begin
            r_sd_a[0][i] <= r_b_right ? AW'(r_b_m[i] >> r_b_sh) : AW'(r_b_m[i] << r_b_sh);
        end
        r_sd_neg[0] <= r_b_neg;
        r_sd_zero[0] <= r_b_zero;
        r_sd_tag[0] <= r_b_tag;
        for (int s = 1; s < NS; s++) begin
            r_sd_a[s] <= r_sd_a[s-1];
            r_sd_neg[s] <= r_sd_neg[s-1];
            r_sd_zero[s] <= r_sd_zero[s-1];
            r_sd_tag[s] <= r_sd_tag[s-1];
        end

        for (int i = 0; i < 3; i++) begin
            r_sqr[i] <= r_sd_a[0][i] * r_sd_a[0][i];
        end
        r_sq_n[0] <= 64'(r_sqr[0]) + 64'(r_sqr[1]) + 64'(r_sqr[2]);
        r_sq_r[0] <= '0;
        for (int k = 1; k <= SQ; k++) begin
            r_sq_n[k] <= n_sq_n[k];
            r_sq_r[k] <= n_sq_r[k];
        end

        r_dv_d[0] <= {w_len, 1'b0};
        for (int i = 0; i < 3; i++) begin
            r_dv_rem[0][i] <= (NW'(r_sd_a[DS-1][i]) << (FRAC + 1)) + NW'(w_len);
            r_dv_q[0][i] <= '0;
        end
        for (int j = 1; j <= QB; j++) begin
            r_dv_d[j] <= r_dv_d[j-1];
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[j][i] <= n_dv_rem[j][i];
                r_dv_q[j][i] <= n_dv_q[j][i];
            end
        end

        for (int i = 0; i < 3; i++) begin
            if (r_sd_zero[NS-1]) begin
                o_vec[i] <= '0;
            end else if (r_sd_neg[NS-1][i]) begin
                o_vec[i] <= -OW'(r_dv_q[QB][i]);
            end else begin
                o_vec[i] <= OW'(r_dv_q[QB][i]);
            end
        end
        o_zero <= r_sd_zero[NS-1];
        o_tag <= r_sd_tag[NS-1];
    end

    assign o_valid = r_v[NP-1];

endmodule

// File: design/lookat_view_matrix.sv
// Channel | Ports                          | Beat taken when
// in      | i_start, o_busy, i_item        | i_start high, o_busy low
// out     | o_strobe, o_result             | o_strobe high, one row per cycle
//
// A new camera setup can enter while earlier ones are still in flight; the
// four row beats share the result port. o_busy comes from a countdown that
// each start beat loads. Each of the two vector normalizers has a 32-step
// square root and a FRAC_BITS+1 step divider.
// Reset is synchronous; the pipeline comes up empty. The receiver cannot stall.
module lookat_view_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  lvm_pkg::t_item i_item,
    output logic          o_strobe,
    output lvm_pkg::t_row  o_result
);

    import lvm_pkg::*;

    localparam int FW  = FRAC_BITS + 2;
    localparam int DW1 = DATA_W + 1;
    localparam int PW  = DATA_W + FW;
    localparam int CRW = PW + 1;
    localparam int TUW = FW + 1;
    localparam int TPW = 2 * FW;
    localparam int TSW = TPW + 1;
    localparam int DPW = FW + DATA_W;
    localparam int DSW = DPW + 2;
    localparam int EPW = TUW + DATA_W;
    localparam int ESW = EPW + 2;
    localparam int TW1 = 6 * DATA_W;
    localparam int TW2 = 3 * DATA_W + 3 * FW + 1;

    function automatic logic signed [63:0] f_rnd(input logic signed [63:0] x);
        logic [63:0] m;
        logic [63:0] r;
        m = x[63] ? -x : x;
        r = (m + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return x[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [DATA_W-1:0] f_sat(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (x < -64'sd2147483648) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return x[DATA_W-1:0];
        end
    endfunction

    logic [1:0]               r_gap;
    logic                     w_accept;

    logic                     r_v0;
    logic [2:0][DW1-1:0]      r_d;
    logic [TW1-1:0]           r_tag1;

    logic                     w_n1_v;
    logic [2:0][FW-1:0]       w_n1_vec;
    logic                     w_n1_zero;
    logic [TW1-1:0]           w_n1_tag;
    logic signed [FW-1:0]     w_fw [3];
    logic signed [DATA_W-1:0] w_up [3];
    logic signed [DATA_W-1:0] w_eye1 [3];

    logic                     r_x1_v;
    logic signed [PW-1:0]     r_x1_p [6];
    logic signed [DATA_W-1:0] r_x1_eye [3];
    logic signed [FW-1:0]     r_x1_fw [3];
    logic                     r_x1_zero;

    logic                     r_x2_v;
    logic [2:0][CRW-1:0]      r_x2_cr;
    logic [TW2-1:0]           r_x2_tag;

    logic                     w_n2_v;
    logic [2:0][FW-1:0]       w_n2_vec;
    logic                     w_n2_zero;
    logic [TW2-1:0]           w_n2_tag;
    logic signed [FW-1:0]     w_rt [3];
    logic signed [FW-1:0]     w_fw2 [3];
    logic signed [DATA_W-1:0] w_eye2 [3];

    logic [5:0]               r_yv;
    logic signed [FW-1:0]     r_y_rt [6][3];
    logic signed [FW-1:0]     r_y_fw [6][3];
    logic signed [DATA_W-1:0] r_y_eye [3][3];
    logic                     r_y_dg [6];
    logic signed [TPW-1:0]    r_y1_tp [6];
    logic signed [DPW-1:0]    r_y1_dr [3];
    logic signed [DPW-1:0]    r_y1_df [3];
    logic signed [TSW-1:0]    r_y2_ts [3];
    logic signed [DSW-1:0]    r_y2_dr;
    logic signed [DSW-1:0]    r_y2_df;
    logic signed [TUW-1:0]    r_y_tu [4][3];
    logic signed [DATA_W-1:0] r_y_r0 [4];
    logic signed [DATA_W-1:0] r_y_r2 [4];
    logic signed [EPW-1:0]    r_y4_ep [3];
    logic signed [ESW-1:0]    r_y5_es;
    logic signed [DATA_W-1:0] r_y6_r1;

    logic signed [FW-1:0]     r_h_rt [3];
    logic signed [TUW-1:0]    r_h_tu [3];
    logic signed [FW-1:0]     r_h_fw [3];
    logic signed [DATA_W-1:0] r_h_r3 [3];
    logic                     r_h_dg;
    logic                     r_act;
    logic [ROW_W-1:0]         r_cnt;
    logic                     r_strobe;
    t_row                     r_out;
    t_row                     n_out;

    assign w_accept = i_start && (r_gap == 2'd0);
    assign o_busy = (r_gap != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= '0;
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= w_accept;
            if (w_accept) begin
                r_gap <= LAST_ROW;
            end else if (r_gap != 2'd0) begin
                r_gap <= r_gap - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d[0] <= DW1'(i_item.target_x) - DW1'(i_item.eye_x);
        r_d[1] <= DW1'(i_item.target_y) - DW1'(i_item.eye_y);
        r_d[2] <= DW1'(i_item.target_z) - DW1'(i_item.eye_z);
        r_tag1 <= {i_item.eye_x, i_item.eye_y, i_item.eye_z,
                   i_item.up_x, i_item.up_y, i_item.up_z};
    end

    lvm_norm #(
        .IN_W  (DW1),
        .FRAC  (FRAC_BITS),
        .TAG_W (TW1)
    ) u_norm_fw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_vec   (r_d),
        .i_tag   (r_tag1),
        .o_valid (w_n1_v),
        .o_vec   (w_n1_vec),
        .o_zero  (w_n1_zero),
        .o_tag   (w_n1_tag)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_fw[i] = $signed(w_n1_vec[i]);
            w_eye1[i] = $signed(w_n1_tag[TW1-1-i*DATA_W -: DATA_W]);
            w_up[i] = $signed(w_n1_tag[3*DATA_W-1-i*DATA_W -: DATA_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1_v <= 1'b0;
            r_x2_v <= 1'b0;
        end else begin
            r_x1_v <= w_n1_v;
            r_x2_v <= r_x1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1_p[0] <= w_up[1] * w_fw[2];
        r_x1_p[1] <= w_up[2] * w_fw[1];
        r_x1_p[2] <= w_up[2] * w_fw[0];
        r_x1_p[3] <= w_up[0] * w_fw[2];
        r_x1_p[4] <= w_up[0] * w_fw[1];
        r_x1_p[5] <= w_up[1] * w_fw[0];
        r_x1_eye <= w_eye1;
        r_x1_fw <= w_fw;
        r_x1_zero <= w_n1_zero;

        for (int i = 0; i < 3; i++) begin
            r_x2_cr[i] <= CRW'(r_x1_p[2*i]) - CRW'(r_x1_p[2*i+1]);
        end
        r_x2_tag <= {r_x1_eye[0], r_x1_eye[1], r_x1_eye[2],
                     r_x1_fw[0], r_x1_fw[1], r_x1_fw[2], r_x1_zero};
    end

    lvm_norm #(
        .IN_W  (CRW),
        .FRAC  (FRAC_BITS),
        .TAG_W (TW2)
    ) u_norm_rt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_x2_v),
        .i_vec   (r_x2_cr),
        .i_tag   (r_x2_tag),
        .o_valid (w_n2_v),
        .o_vec   (w_n2_vec),
        .o_zero  (w_n2_zero),
        .o_tag   (w_n2_tag)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rt[i] = $signed(w_n2_vec[i]);
            w_eye2[i] = $signed(w_n2_tag[TW2-1-i*DATA_W -: DATA_W]);
            w_fw2[i] = $signed(w_n2_tag[3*FW-i*FW -: FW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yv <= '0;
        end else begin
            r_yv <= {r_yv[4:0], w_n2_v};
        end
    end

    always_ff @(posedge i_clk) begin
        r_y_rt[0] <= w_rt;
        r_y_fw[0] <= w_fw2;
        r_y_eye[0] <= w_eye2;
        r_y_dg[0] <= w_n2_zero || w_n2_tag[0];
        for (int s = 1; s < 6; s++) begin
            r_y_rt[s] <= r_y_rt[s-1];
            r_y_fw[s] <= r_y_fw[s-1];
            r_y_dg[s] <= r_y_dg[s-1];
        end
        r_y_eye[1] <= r_y_eye[0];
        r_y_eye[2] <= r_y_eye[1];

        r_y1_tp[0] <= w_fw2[1] * w_rt[2];
        r_y1_tp[1] <= w_fw2[2] * w_rt[1];
        r_y1_tp[2] <= w_fw2[2] * w_rt[0];
        r_y1_tp[3] <= w_fw2[0] * w_rt[2];
        r_y1_tp[4] <= w_fw2[0] * w_rt[1];
        r_y1_tp[5] <= w_fw2[1] * w_rt[0];
        for (int i = 0; i < 3; i++) begin
            r_y1_dr[i] <= w_rt[i] * w_eye2[i];
            r_y1_df[i] <= w_fw2[i] * w_eye2[i];
        end

        for (int i = 0; i < 3; i++) begin
            r_y2_ts[i] <= TSW'(r_y1_tp[2*i]) - TSW'(r_y1_tp[2*i+1]);
        end
        r_y2_dr <= DSW'(r_y1_dr[0]) + DSW'(r_y1_dr[1]) + DSW'(r_y1_dr[2]);
        r_y2_df <= DSW'(r_y1_df[0]) + DSW'(r_y1_df[1]) + DSW'(r_y1_df[2]);

        for (int i = 0; i < 3; i++) begin
            r_y_tu[0][i] <= TUW'(f_rnd(64'(r_y2_ts[i])));
        end
        r_y_r0[0] <= f_sat(-f_rnd(64'(r_y2_dr)));
        r_y_r2[0] <= f_sat(-f_rnd(64'(r_y2_df)));
        for (int s = 1; s < 4; s++) begin
            r_y_tu[s] <= r_y_tu[s-1];
            r_y_r0[s] <= r_y_r0[s-1];
            r_y_r2[s] <= r_y_r2[s-1];
        end

        for (int i = 0; i < 3; i++) begin
            r_y4_ep[i] <= r_y_tu[0][i] * r_y_eye[2][i];
        end
        r_y5_es <= ESW'(r_y4_ep[0]) + ESW'(r_y4_ep[1]) + ESW'(r_y4_ep[2]);
        r_y6_r1 <= f_sat(-f_rnd(64'(r_y5_es)));
    end

    always_comb begin
        n_out = r_out;
        n_out.row_index = r_cnt;
        n_out.last_row = (r_cnt == LAST_ROW);
        n_out.degenerate = r_h_dg;
        case (r_cnt)
            2'd0, 2'd1, 2'd2: begin
                n_out.col_0 = DATA_W'(r_h_rt[r_cnt]);
                n_out.col_1 = DATA_W'(r_h_tu[r_cnt]);
                n_out.col_2 = DATA_W'(r_h_fw[r_cnt]);
                n_out.col_3 = '0;
            end
            LAST_ROW: begin
                n_out.col_0 = r_h_r3[0];
                n_out.col_1 = r_h_r3[1];
                n_out.col_2 = r_h_r3[2];
                n_out.col_3 = DATA_W'(1) << FRAC_BITS;
            end
            default: begin
                n_out.col_3 = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_cnt <= FIRST_ROW;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_act;
            if (r_yv[5]) begin
                r_act <= 1'b1;
                r_cnt <= FIRST_ROW;
            end else if (r_act) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == LAST_ROW) begin
                    r_act <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_act) begin
            r_out <= n_out;
        end
        if (r_yv[5]) begin
            r_h_rt <= r_y_rt[5];
            r_h_fw <= r_y_fw[5];
            r_h_tu <= r_y_tu[3];
            r_h_r3[0] <= r_y_r0[3];
            r_h_r3[1] <= r_y6_r1;
            r_h_r3[2] <= r_y_r2[3];
            r_h_dg <= r_y_dg[5];
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

// File: design/lvm_check.sv
module lvm_check (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_start,
    input logic          o_busy,
    input logic          o_strobe,
    input lvm_pkg::t_row o_result
);

    import lvm_pkg::*;

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("busy did not rise after a start beat");

    a_rows_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.row_index != LAST_ROW |=>
            o_strobe && o_result.row_index == $past(o_result.row_index) + 2'd1)
        else $error("row beats broke sequence");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_result.last_row == (o_result.row_index == LAST_ROW))
        else $error("last_row does not match row_index");

    a_degen_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.row_index != LAST_ROW |=> $stable(o_result.degenerate))
        else $error("degenerate changed within one matrix");

    a_col3_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.row_index != LAST_ROW |-> o_result.col_3 == '0)
        else $error("col_3 nonzero on an axis row");

endmodule

bind lookat_view_matrix lvm_check u_lvm_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
